// ===== hdl/rte_pkg.sv =====
package rte_pkg;

  // Time range and fixed-point layout of the state.
  localparam int TIME_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Integer part of a sample or state value: wide enough for the time range and for the
  // 32-bit seed deviation.
  localparam int SAMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int VAL_W  = SAMP_W + FRAC_BITS;

  // Output fields are 32 bits; the timeout saturates at the smaller of the two ranges.
  localparam int OUT_W    = 32;
  localparam int CAP_BITS = (TIME_BITS < OUT_W) ? TIME_BITS : OUT_W;
  localparam int TMO_W    = SAMP_W + 3;

  // Gains are Q0.16; one is 2^16, so a gain needs 17 bits.
  localparam int GAIN_FRAC = 16;
  localparam int GAIN_W    = GAIN_FRAC + 1;
  localparam logic [GAIN_W-1:0]    GAIN_ONE   = GAIN_W'(1) << GAIN_FRAC;
  localparam logic [GAIN_FRAC-1:0] GAIN_MAX   = GAIN_FRAC'(1) << (GAIN_FRAC - 1);
  localparam logic [GAIN_FRAC-1:0] GAIN_RESET = GAIN_FRAC'(8192);

  // Shared multiplier: gain times one operand chunk.
  localparam int CHUNK_W = 24;
  localparam int NCHUNK  = (VAL_W + CHUNK_W - 1) / CHUNK_W;
  localparam int CHK_IW  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int VPAD_W  = NCHUNK * CHUNK_W;
  localparam int PROD_W  = GAIN_W + CHUNK_W;
  localparam int ACC_W   = VAL_W + GAIN_W;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (GAIN_FRAC - 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_GAIN    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DEVIATION = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EST_MUL,
    ST_EST_END,
    ST_ERR,
    ST_DEV_MUL,
    ST_DEV_END,
    ST_OUT
  } rte_state_t;

  typedef struct packed {
    logic              init;
    logic              mul_en;
    logic [CHK_IW-1:0] chunk;
  } rte_mac_ctl_t;

endpackage

// ===== hdl/rtt_timeout_estimator.sv =====
// Adaptive retransmission-timeout estimator of the Jacobson/Karels kind. Each input transfer
// carries one acknowledged packet's armed timeout and the time left on its timer; their
// difference, clamped at zero and at the time range, is the RTT sample. The first sample
// after reset seeds the estimate with itself and the deviation with initial_deviation.
// The estimate is then blended with the sample at gain alpha (smoothing_gain, Q0.16,
// clamped at one half), and the deviation with the absolute error against the new
// estimate at gain 2*alpha, both rounded to nearest with 16 fraction bits kept in state.
// Every input transfer yields exactly one output transfer with the new timeout
// (estimate plus four deviations, saturated) and the integer parts of both state values.
// Each update runs through one shared 17 x 24 multiplier and accumulator: every blend
// multiplies each of the NCHUNK 24-bit chunks of the old value and then of the new operand
// by its gain, and then drains the last product into the accumulator; NCHUNK is two at
// the default widths. The block takes no new item until the current one is through and
// its result has gone to the output register, and in_stall is high for
// the whole update. A finished result waits in the output register, so the next item is
// taken while it is still stalled; only a second finished result waits for it to drain.
// Configuration writes are taken in any cycle and should be made while no item is in work.
module rtt_timeout_estimator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [rte_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rte_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [31:0]                       in_armed_timeout_ns,
  input  logic [29:0]                       in_remaining_ns,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rte_pkg::OUT_W-1:0]         out_timeout_ns,
  output logic [rte_pkg::OUT_W-1:0]         out_estimated_rtt_ns,
  output logic [rte_pkg::OUT_W-1:0]         out_deviation_ns
);
  import rte_pkg::*;

  // Configuration registers.
  logic [GAIN_FRAC-1:0] gain_r, gain_nxt;
  logic [31:0]          init_dev_r, init_dev_nxt;

  // Sequencer and state.
  rte_state_t           state_r, state_nxt;
  logic                 op_r, op_nxt;
  logic [CHK_IW-1:0]    chk_r, chk_nxt;
  logic                 seeded_r, seeded_nxt;
  logic [VAL_W-1:0]     est_r, est_nxt;
  logic [VAL_W-1:0]     dev_r, dev_nxt;
  // Holds the scaled sample during the estimate blend and the error during the other.
  logic [VAL_W-1:0]     opv_r, opv_nxt;
  logic [GAIN_FRAC-1:0] a_r, a_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_tmo_r, out_tmo_nxt;
  logic [OUT_W-1:0]     out_est_r, out_est_nxt;
  logic [OUT_W-1:0]     out_dev_r, out_dev_nxt;

  // Shared multiply-accumulate unit.
  rte_mac_ctl_t         mac_ctl;
  logic [GAIN_W-1:0]    mac_gain;
  logic [CHUNK_W-1:0]   mac_opnd;
  logic [ACC_W-1:0]     mac_acc;

  // Combinational helpers.
  logic                 in_xfer;
  logic                 out_xfer;
  logic [SAMP_W-1:0]    diff;
  logic [SAMP_W-1:0]    sample;
  logic [SAMP_W-1:0]    time_max;
  logic [VAL_W-1:0]     samp_scaled;
  logic [VAL_W-1:0]     blend_res;
  logic [VAL_W+2:0]     tmo_sum;
  logic [TMO_W-1:0]     tmo_full;
  logic [OUT_W-1:0]     tmo_cap;
  logic [GAIN_W-1:0]    a_ext;
  logic [GAIN_W-1:0]    a2_ext;
  logic [VAL_W-1:0]     mul_val;
  logic [VPAD_W-1:0]    mul_pad;
  logic                 last_chunk;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  // Sample: armed minus remaining, zero when the timer shows more left than it was armed
  // with, and clamped at the top of the time range.
  assign time_max = ~SAMP_W'(0) >> (SAMP_W - TIME_BITS);
  always_comb begin
    if (in_armed_timeout_ns > 32'(in_remaining_ns)) begin
      diff = SAMP_W'(in_armed_timeout_ns - 32'(in_remaining_ns));
    end else begin
      diff = '0;
    end
    sample = (diff > time_max) ? time_max : diff;
  end
  assign samp_scaled = VAL_W'(sample) << FRAC_BITS;

  // The accumulator holds the blend plus one half of an LSB; dropping the gain fraction
  // rounds to nearest with ties up.
  assign blend_res = mac_acc[GAIN_FRAC +: VAL_W];

  // Timeout from the new deviation straight out of the accumulator.
  assign tmo_sum  = {3'b000, est_r} + {1'b0, blend_res, 2'b00};
  assign tmo_full = tmo_sum[VAL_W+2:FRAC_BITS];
  assign tmo_cap  = ~OUT_W'(0) >> (OUT_W - CAP_BITS);

  // Gain and operand chunk for the current multiply step: op 0 is the old state value,
  // op 1 is the sample (estimate blend) or the error (deviation blend).
  assign a_ext  = {1'b0, a_r};
  assign a2_ext = {a_r, 1'b0};
  always_comb begin
    if (state_r == ST_DEV_MUL) begin
      mac_gain = op_r ? a2_ext : (GAIN_ONE - a2_ext);
      mul_val  = op_r ? opv_r : dev_r;
    end else begin
      mac_gain = op_r ? a_ext : (GAIN_ONE - a_ext);
      mul_val  = op_r ? opv_r : est_r;
    end
  end
  assign mul_pad    = VPAD_W'(mul_val);
  assign mac_opnd   = mul_pad[chk_r*CHUNK_W +: CHUNK_W];
  assign last_chunk = (chk_r == CHK_IW'(NCHUNK - 1));

  always_comb begin
    mac_ctl.mul_en = (state_r == ST_EST_MUL) || (state_r == ST_DEV_MUL);
    mac_ctl.init   = mac_ctl.mul_en && !op_r && (chk_r == '0);
    mac_ctl.chunk  = chk_r;
  end

  rte_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .gain  (mac_gain),
    .opnd  (mac_opnd),
    .acc   (mac_acc)
  );

  // Configuration writes; an unknown index is ignored.
  always_comb begin
    gain_nxt     = gain_r;
    init_dev_nxt = init_dev_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SMOOTHING_GAIN:    gain_nxt     = cfg_wr_data[GAIN_FRAC-1:0];
        CFG_INITIAL_DEVIATION: init_dev_nxt = cfg_wr_data[31:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    chk_nxt       = chk_r;
    seeded_nxt    = seeded_r;
    est_nxt       = est_r;
    dev_nxt       = dev_r;
    opv_nxt       = opv_r;
    a_nxt         = a_r;
    out_valid_nxt = out_xfer ? 1'b0 : out_valid_r;
    out_tmo_nxt   = out_tmo_r;
    out_est_nxt   = out_est_r;
    out_dev_nxt   = out_dev_r;
    in_stall      = (state_r != ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          opv_nxt = samp_scaled;
          a_nxt   = (gain_r > GAIN_MAX) ? GAIN_MAX : gain_r;
          if (!seeded_r) begin
            est_nxt    = samp_scaled;
            dev_nxt    = VAL_W'(init_dev_r) << FRAC_BITS;
            seeded_nxt = 1'b1;
          end
          op_nxt    = 1'b0;
          chk_nxt   = '0;
          state_nxt = ST_EST_MUL;
        end
      end
      ST_EST_MUL, ST_DEV_MUL: begin
        if (last_chunk) begin
          chk_nxt = '0;
          if (op_r) begin
            op_nxt    = 1'b0;
            state_nxt = (state_r == ST_EST_MUL) ? ST_EST_END : ST_DEV_END;
          end else begin
            op_nxt = 1'b1;
          end
        end else begin
          chk_nxt = chk_r + CHK_IW'(1);
        end
      end
      ST_EST_END: begin
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        // New estimate, and the absolute error of the sample against it.
        est_nxt   = blend_res;
        opv_nxt   = (opv_r >= blend_res) ? (opv_r - blend_res) : (blend_res - opv_r);
        state_nxt = ST_DEV_MUL;
      end
      ST_DEV_END: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // Wait only while an earlier result is still stalled in the output register.
        if (!out_valid_r || !out_stall) begin
          dev_nxt       = blend_res;
          out_valid_nxt = 1'b1;
          out_tmo_nxt   = (|tmo_full[TMO_W-1:CAP_BITS]) ? tmo_cap : tmo_full[OUT_W-1:0];
          out_est_nxt   = est_r[FRAC_BITS +: OUT_W];
          out_dev_nxt   = blend_res[FRAC_BITS +: OUT_W];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_RESET;
      init_dev_r  <= '0;
      state_r     <= ST_IDLE;
      op_r        <= 1'b0;
      chk_r       <= '0;
      seeded_r    <= 1'b0;
      est_r       <= '0;
      dev_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      gain_r      <= gain_nxt;
      init_dev_r  <= init_dev_nxt;
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      chk_r       <= chk_nxt;
      seeded_r    <= seeded_nxt;
      est_r       <= est_nxt;
      dev_r       <= dev_nxt;
      out_valid_r <= out_valid_nxt;
    end
    opv_r     <= opv_nxt;
    a_r       <= a_nxt;
    out_tmo_r <= out_tmo_nxt;
    out_est_r <= out_est_nxt;
    out_dev_r <= out_dev_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_timeout_ns       = out_tmo_r;
  assign out_estimated_rtt_ns = out_est_r;
  assign out_deviation_ns     = out_dev_r;

`ifndef SYNTHESIS
  // An accepted item always starts with the estimate blend.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_EST_MUL))
    else $error("accepted item did not start the estimate blend");

  // The error step only follows the drain of the estimate blend.
  a_err_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ERR) |-> ($past(state_r) == ST_EST_END))
    else $error("error step entered out of sequence");

  // Finishing an item always leaves a result in the output register.
  a_finish_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_OUT) && (state_nxt == ST_IDLE)) |=> out_valid_r)
    else $error("finished item left no result");

  // Once seeded, the state stays seeded until reset.
  a_seeded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(seeded_r))
    else $error("seeded flag dropped without reset");
`endif

endmodule

// ===== hdl/rte_mac.sv =====
module rte_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rte_pkg::rte_mac_ctl_t               ctl,
  input  logic [rte_pkg::GAIN_W-1:0]          gain,
  input  logic [rte_pkg::CHUNK_W-1:0]         opnd,
  output logic [rte_pkg::ACC_W-1:0]           acc
);
  import rte_pkg::*;

  // The product of one cycle is added to the accumulator in the next one.
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [CHK_IW-1:0] pidx_r, pidx_nxt;
  logic              pv_r, pv_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;

  always_comb begin
    prod_nxt = gain * opnd;
    pidx_nxt = ctl.chunk;
    pv_nxt   = ctl.mul_en;
    if (ctl.init) begin
      acc_nxt = ROUND_HALF;
    end else if (pv_r) begin
      acc_nxt = acc_r + (ACC_W'(prod_r) << (pidx_r * CHUNK_W));
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= pv_nxt;
    end
    prod_r <= prod_nxt;
    pidx_r <= pidx_nxt;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== sim/rtt_timeout_estimator_checker.sv =====
module rtt_timeout_estimator_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [rte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rte_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [31:0]                    in_armed_timeout_ns,
  input  logic [29:0]                    in_remaining_ns,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [rte_pkg::OUT_W-1:0]      out_timeout_ns,
  input  logic [rte_pkg::OUT_W-1:0]      out_estimated_rtt_ns,
  input  logic [rte_pkg::OUT_W-1:0]      out_deviation_ns,
  output int                             mismatches,
  output int                             outstanding,
  output int                             results_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import rte_pkg::*;

  localparam int              Q_FRAC      = 16;
  localparam logic [16:0]     UNITY_GAIN  = 17'd65536;
  localparam logic [16:0]     HALF_GAIN   = 17'd32768;
  localparam logic [15:0]     GAIN_AT_RST = 16'd8192;
  localparam logic [63:0]     TIME_MAX    = (64'd1 << TIME_BITS) - 64'd1;
  localparam logic [63:0]     TIMEOUT_CAP = (TIME_BITS < 32) ? TIME_MAX : 64'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] timeout_ns;
    logic [31:0] estimated_rtt_ns;
    logic [31:0] deviation_ns;
  } rto_result_t;

  // Register copies, and smoothed state with FRAC_BITS fraction bits.
  logic [15:0]      gain_reg;
  logic [31:0]      init_dev_reg;
  logic [VAL_W-1:0] srtt_q;
  logic [VAL_W-1:0] rttvar_q;
  logic             seeded_q;

  rto_result_t      pending_rto[$];
  rto_result_t      want_rto;
  logic [2:0][31:0] want_words;
  logic [2:0][31:0] got_words;
  int               fault_cnt;
  int               result_cnt;
  string            field_name [3] = '{"deviation_ns", "estimated_rtt_ns", "timeout_ns"};

  // Rounded Q0.16 weighted sum of two fixed-point values, ties rounded up.
  function automatic logic [VAL_W-1:0] weigh(input logic [16:0] keep_gain,
                                             input logic [VAL_W-1:0] old_val,
                                             input logic [16:0] new_gain,
                                             input logic [VAL_W-1:0] new_val);
    logic [VAL_W+17:0] acc;
    acc = keep_gain * old_val + new_gain * new_val + (1 << (Q_FRAC - 1));
    return VAL_W'(acc >> Q_FRAC);
  endfunction

  // Folds one RTT sample into the estimator state and returns the new timeout.
  function automatic rto_result_t rto_update(input logic [31:0] armed,
                                             input logic [29:0] remain);
    logic [63:0]      rtt_sample;
    logic [VAL_W-1:0] sample_fx;
    logic [VAL_W-1:0] abs_err;
    logic [16:0]      alpha;
    logic [16:0]      beta;
    logic [VAL_W+2:0] tmo;
    rto_result_t      res;
    rtt_sample = (armed > 32'(remain)) ? 64'(armed) - 64'(remain) : 64'd0;
    if (rtt_sample > TIME_MAX)
      rtt_sample = TIME_MAX;
    sample_fx = VAL_W'(rtt_sample << FRAC_BITS);
    alpha = (17'(gain_reg) > HALF_GAIN) ? HALF_GAIN : 17'(gain_reg);
    beta  = alpha << 1;
    if (!seeded_q) begin
      srtt_q   = sample_fx;
      rttvar_q = VAL_W'(init_dev_reg) << FRAC_BITS;
      seeded_q = 1'b1;
    end
    srtt_q   = weigh(UNITY_GAIN - alpha, srtt_q, alpha, sample_fx);
    abs_err  = (sample_fx >= srtt_q) ? sample_fx - srtt_q : srtt_q - sample_fx;
    rttvar_q = weigh(UNITY_GAIN - beta, rttvar_q, beta, abs_err);
    tmo = ((VAL_W + 3)'(srtt_q) + ((VAL_W + 3)'(rttvar_q) << 2)) >> FRAC_BITS;
    if (64'(tmo) > TIMEOUT_CAP)
      tmo = (VAL_W + 3)'(TIMEOUT_CAP);
    res.timeout_ns       = tmo[31:0];
    res.estimated_rtt_ns = 32'(srtt_q >> FRAC_BITS);
    res.deviation_ns     = 32'(rttvar_q >> FRAC_BITS);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      gain_reg     = GAIN_AT_RST;
      init_dev_reg = '0;
      srtt_q       = '0;
      rttvar_q     = '0;
      seeded_q     = 1'b0;
      fault_cnt    = 0;
      result_cnt   = 0;
      pending_rto.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SMOOTHING_GAIN:    gain_reg = cfg_wr_data[15:0];
          CFG_INITIAL_DEVIATION: init_dev_reg = cfg_wr_data[31:0];
          default: ;
        endcase
      end
      // Results are matched before new samples are queued, so a result is always
      // held against samples taken at earlier edges.
      if (out_valid && !out_stall) begin
        result_cnt++;
        got_words = {out_timeout_ns, out_estimated_rtt_ns, out_deviation_ns};
        if (pending_rto.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= 10)
            $display("%0t: result with no sample pending: timeout %0d srtt %0d rttvar %0d",
                     $realtime, out_timeout_ns, out_estimated_rtt_ns, out_deviation_ns);
        end else begin
          want_rto   = pending_rto.pop_front();
          want_words = want_rto;
          for (int k = 0; k < 3; k++) begin
            if (got_words[k] !== want_words[k]) begin
              fault_cnt++;
              if (fault_cnt <= 10)
                $display("%0t: result %0d %s expected %0d got %0d", $realtime, result_cnt,
                         field_name[k], want_words[k], got_words[k]);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        pending_rto.push_back(rto_update(in_armed_timeout_ns, in_remaining_ns));
    end
    mismatches      <= fault_cnt;
    outstanding     <= pending_rto.size();
    results_checked <= result_cnt;
  end

endmodule

// ===== sim/rtt_timeout_estimator_test.sv =====
// Stimulus and verdict for the RTT timeout estimator. The checker beside the block
// predicts and compares every result; this module only drives transfers, the
// configuration port and output back-pressure.
module rtt_timeout_estimator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rte_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 220;
  // One long receiver hold-off, well beyond the time the block needs to fill up.
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 40;

  logic                  clk                 = 1'b0;
  logic                  rst_n               = 1'b0;
  logic                  cfg_wr_en           = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index           = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data         = '0;
  logic                  in_valid            = 1'b0;
  logic [31:0]           in_armed_timeout_ns = '0;
  logic [29:0]           in_remaining_ns     = '0;
  logic                  out_stall           = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [OUT_W-1:0]      out_timeout_ns;
  logic [OUT_W-1:0]      out_estimated_rtt_ns;
  logic [OUT_W-1:0]      out_deviation_ns;

  int mismatches;
  int outstanding;
  int results_checked;
  int samples_sent  = 0;
  int gain_settings = 0;
  // Set for the last phase: from then on neither side idles.
  bit quiet         = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  rtt_timeout_estimator dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_armed_timeout_ns  (in_armed_timeout_ns),
    .in_remaining_ns      (in_remaining_ns),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_timeout_ns       (out_timeout_ns),
    .out_estimated_rtt_ns (out_estimated_rtt_ns),
    .out_deviation_ns     (out_deviation_ns)
  );

  rtt_timeout_estimator_checker rto_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_armed_timeout_ns  (in_armed_timeout_ns),
    .in_remaining_ns      (in_remaining_ns),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_timeout_ns       (out_timeout_ns),
    .out_estimated_rtt_ns (out_estimated_rtt_ns),
    .out_deviation_ns     (out_deviation_ns),
    .mismatches           (mismatches),
    .outstanding          (outstanding),
    .results_checked      (results_checked)
  );

  // A register write raises the enable for a single cycle, then lowers it for one cycle,
  // so back-to-back writes never put two assignments on it in the same time step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == CFG_SMOOTHING_GAIN)
      gain_settings++;
  endtask

  // Stops offering and waits until every queued sample has come back as a result.
  // Every sample yields a result, so an empty queue means the block is idle. The
  // checker publishes its count through a register, hence the first edge.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
  endtask

  // With the given chance, the sender goes quiet for a burst before the next transfer.
  task automatic maybe_gap(input int pct);
    if (!quiet && $urandom_range(1, 100) <= pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Offers one acknowledgement and holds it until the block takes it. Valid stays high
  // on return, so the next transfer can follow without a bubble.
  task automatic send_ack(input logic [31:0] armed, input logic [29:0] remain);
    in_valid            <= 1'b1;
    in_armed_timeout_ns <= armed;
    in_remaining_ns     <= remain;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    samples_sent++;
  endtask

  // Receiver: random stall bursts and free-running stretches, one long hold-off once
  // enough traffic has gone by, and no stalls at all once the run has gone quiet.
  initial begin
    bit  held_off;
    bit  stall_level;
    int  span;
    held_off = 1'b0;
    wait (rst_n);
    forever begin
      if (quiet) begin
        stall_level = 1'b0;
        span        = 1;
      end else if (!held_off && results_checked >= 300) begin
        held_off    = 1'b1;
        stall_level = 1'b1;
        span        = HOLD_CYCLES;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_level = 1'b1;
        span        = $urandom_range(1, 13);
      end else begin
        stall_level = 1'b0;
        span        = $urandom_range(1, 30);
      end
      out_stall <= stall_level;
      repeat (span) @(posedge clk);
    end
  end

  // Hard stop in case the block hangs; several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("rtt_timeout_estimator_test NOT OK");
    $finish;
  end

  initial begin
    logic [31:0] armed;
    logic [29:0] remain;
    logic [31:0] gain_word;
    int          base_rtt;
    int          gap_pct;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The initial deviation only counts at the very first sample after reset, so the
    // largest value goes in before anything is sent. The gain keeps its reset value
    // here, and the huge deviation drives the timeout into saturation for a while.
    write_reg(CFG_INITIAL_DEVIATION, 32'hFFFF_FFFF);
    maybe_gap(30); send_ack(32'd1_000_000, 30'd250_000);      // first sample seeds state
    maybe_gap(30); send_ack(32'd5, 30'd1_000);                // remaining exceeds armed
    maybe_gap(30); send_ack(32'd0, 30'd0);
    maybe_gap(30); send_ack(32'hFFFF_FFFF, 30'd0);            // largest sample
    maybe_gap(30); send_ack(32'hFFFF_FFFF, 30'h3FFF_FFFF);    // remaining past 999999999
    maybe_gap(30); send_ack(32'd1_000_000_000, 30'd999_999_999);
    maybe_gap(30); send_ack(32'h3FFF_FFFF, 30'h3FFF_FFFF);    // equal, so the sample is zero
    maybe_gap(30); send_ack(32'h8000_0000, 30'd1);

    // Zero gain freezes both averages; the deviation write must have no effect now.
    wait_drained();
    write_reg(CFG_SMOOTHING_GAIN, 32'd0);
    write_reg(CFG_INITIAL_DEVIATION, 32'd0);
    send_ack(32'd123_456, 30'd0);
    send_ack(32'hFFFF_FFFF, 30'd0);

    // Every gain bit set, upper data bits included: the block keeps 16 bits and
    // clamps the gain at one half.
    wait_drained();
    write_reg(CFG_SMOOTHING_GAIN, 32'hFFFF_FFFF);
    send_ack(32'd2_000_000, 30'd100);
    send_ack(32'd0, 30'd7);
    send_ack(32'hFFFF_FFFF, 30'd0);

    // Exactly one half, then the smallest nonzero gain.
    wait_drained();
    write_reg(CFG_SMOOTHING_GAIN, 32'd32768);
    send_ack(32'd40_000, 30'd10_000);
    send_ack(32'd7, 30'd0);
    wait_drained();
    write_reg(CFG_SMOOTHING_GAIN, 32'd1);
    send_ack(32'd1_000, 30'd0);

    // Random phases. Most acknowledgements carry a steady RTT with jitter, so the
    // estimate settles and the deviation shrinks; the rest are corner values.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0:       gain_word = 32'd32768;
        1:       gain_word = 32'd0;
        2:       gain_word = 32'hFFFF_FFFF;
        default: begin
          case ($urandom_range(0, 3))
            0:       gain_word = $urandom_range(0, 32768);
            1:       gain_word = $urandom_range(1, 2048);
            2:       gain_word = $urandom();
            default: gain_word = 32'd8192;
          endcase
        end
      endcase
      write_reg(CFG_SMOOTHING_GAIN, gain_word);
      if ($urandom_range(0, 1) == 1)
        write_reg(CFG_INITIAL_DEVIATION, $urandom());
      quiet    = (phase == PHASES - 1);
      base_rtt = $urandom_range(10_000, 5_000_000);
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 20;
        default: gap_pct = 60;
      endcase
      repeat (PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          6: begin
            armed  = $urandom();
            remain = 30'($urandom());
          end
          7: begin
            remain = 30'($urandom());
            armed  = $urandom_range(0, 32'(remain));
          end
          8: begin
            armed  = $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
            remain = 30'($urandom_range(0, 1_000));
          end
          9: begin
            armed  = $urandom_range(0, 50);
            remain = 30'($urandom_range(0, 50));
          end
          default: begin
            remain = 30'($urandom_range(0, 999_999_999));
            armed  = 32'(remain) + base_rtt + $urandom_range(0, base_rtt / 4);
          end
        endcase
        maybe_gap(gap_pct);
        send_ack(armed, remain);
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Coverage: %0d acknowledgements in, %0d results checked, %0d gain settings.",
             samples_sent, results_checked, gain_settings);
    $display("Gains of zero, one half and over-range, a saturated seed deviation and a long"
             , " output hold-off were all exercised.");
    if (mismatches == 0) begin
      $display("rtt_timeout_estimator_test OK");
    end else begin
      $display("rtt_timeout_estimator_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rte_pkg.sv
hdl/rte_mac.sv
hdl/rtt_timeout_estimator.sv
sim/rtt_timeout_estimator_checker.sv
sim/rtt_timeout_estimator_test.sv
